// File: sv/mwut_pkg.sv
// Shared types and constants of the memory word use tracker.
package mwut_pkg;

    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BASE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACKING_ENABLE = 1'b1;

    localparam logic [1:0] ACT_MARK    = 2'd0;
    localparam logic [1:0] ACT_FETCH   = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    localparam logic [7:0] SINGLE_WORD_BYTES = 8'd4;
    localparam logic [7:0] MAX_ACCESS_BYTES  = 8'd8;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] address;
        logic [7:0]  access_bytes;
    } t_cmd;

    typedef struct packed {
        logic [63:0] first_addr;
        logic [63:0] last_addr;
        logic [14:0] range_bytes;
        logic        range_found;
        logic        scan_done;
        logic        access_ignored;
    } t_res;

endpackage

// File: sv/memory_word_use_tracker.sv
// Word use tracker: bitmap of used 4-byte words in a window, with range scan.
//
//  channel  | signals                          | direction
//  ---------+----------------------------------+----------
//  command  | i_start, o_busy, i_cmd           | in
//  result   | o_done, o_res                    | out
//  config   | i_cfg_we, i_cfg_idx, i_cfg_wdata | in
//
// After reset the bitmap is cleared one row per cycle, all TRACK_ROWS rows (512 by
// default), with o_busy high. A restart or unused action answers in the cycle after
// acceptance. A mark forms the window offset and checks it, then is dropped or
// reads and writes back each word it sets, one or two. A fetch reads rows and checks
// words in turn; a run's first and last address come from the shared address adder.
// o_done pulses for one cycle per command accepted; the receiver cannot stall it.
module memory_word_use_tracker #(
    parameter int unsigned WINDOW_BYTES = 16384,
    parameter int unsigned BITMAP_BYTES = 512
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  mwut_pkg::t_cmd                i_cmd,
    output logic                          o_done,
    output mwut_pkg::t_res                o_res,
    input  logic                          i_cfg_we,
    input  logic [mwut_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]                   i_cfg_wdata
);
    import mwut_pkg::*;

    localparam int unsigned WINDOW_WORDS = WINDOW_BYTES / 4;
    localparam int unsigned MAP_WORDS    = BITMAP_BYTES * 8;
    localparam int unsigned TRACK_WORDS  =
        (WINDOW_WORDS < MAP_WORDS) ? WINDOW_WORDS : MAP_WORDS;
    localparam int unsigned TRACK_ROWS   = (TRACK_WORDS + 7) / 8;
    localparam int unsigned WW           = $clog2(TRACK_WORDS);
    localparam int unsigned CW           = $clog2(TRACK_WORDS + 1);
    localparam int unsigned RW           = WW - 3;
    localparam logic [63:0] TRACK_BYTES  = 64'(TRACK_WORDS) * 64'd4;

    typedef enum logic [9:0] {
        S_CLR  = 10'b00_0000_0001,
        S_IDLE = 10'b00_0000_0010,
        S_MOFF = 10'b00_0000_0100,
        S_MCHK = 10'b00_0000_1000,
        S_MRD  = 10'b00_0001_0000,
        S_MWR  = 10'b00_0010_0000,
        S_SRD  = 10'b00_0100_0000,
        S_SBIT = 10'b00_1000_0000,
        S_SF1  = 10'b01_0000_0000,
        S_SF2  = 10'b10_0000_0000
    } t_state;

    logic [7:0] mem [TRACK_ROWS];

    t_state        r_state, n_state;
    t_cmd          r_cmd, n_cmd;
    t_res          r_res, n_res;
    logic          r_done, n_done;
    logic [63:0]   r_base, n_base;
    logic          r_en, n_en;
    logic [63:0]   r_off, n_off;
    logic [WW-1:0] r_w, n_w;
    logic          r_second, n_second;
    logic [CW-1:0] r_cur, n_cur;
    logic          r_open, n_open;
    logic [WW-1:0] r_first, n_first;
    logic [WW-1:0] r_last, n_last;
    logic [RW-1:0] r_clr, n_clr;
    logic [7:0]    r_rdata;

    logic          mem_we;
    logic [RW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [RW-1:0] mem_raddr;

    logic [WW:0]   next_w;
    logic [CW-1:0] next_cur;
    logic          cur_bit;
    logic [WW:0]   run_words;
    logic [WW-1:0] sum_word;
    logic [63:0]   word_addr;

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

    assign next_w    = {1'b0, r_w} + 1'b1;
    assign next_cur  = r_cur + 1'b1;
    assign cur_bit   = r_rdata[r_cur[2:0]];
    assign run_words = {1'b0, r_last} - {1'b0, r_first} + 1'b1;
    assign sum_word  = (r_state == S_SF1) ? r_first : r_last;
    assign word_addr = r_base + (64'(sum_word) << 2);

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_res     = r_res;
        n_done    = 1'b0;
        n_base    = r_base;
        n_en      = r_en;
        n_off     = r_off;
        n_w       = r_w;
        n_second  = r_second;
        n_cur     = r_cur;
        n_open    = r_open;
        n_first   = r_first;
        n_last    = r_last;
        n_clr     = r_clr;
        mem_we    = 1'b0;
        mem_waddr = r_w[WW-1:3];
        mem_wdata = r_rdata | (8'd1 << r_w[2:0]);
        mem_re    = 1'b0;
        mem_raddr = r_w[WW-1:3];

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WINDOW_BASE:     n_base = i_cfg_wdata;
                CFG_TRACKING_ENABLE: n_en   = i_cfg_wdata[0];
                default:             n_base = r_base;
            endcase
        end

        unique case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == RW'(TRACK_ROWS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_cmd = i_cmd;
                    n_res = '0;
                    unique case (i_cmd.action)
                        ACT_MARK: begin
                            n_state = S_MOFF;
                        end
                        ACT_FETCH: begin
                            n_open  = 1'b0;
                            n_state = S_SRD;
                        end
                        ACT_RESTART: begin
                            n_cur   = '0;
                            n_open  = 1'b0;
                            n_first = '0;
                            n_done  = 1'b1;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_MOFF: begin
                n_off   = r_cmd.address - r_base;
                n_state = S_MCHK;
            end
            S_MCHK: begin
                if (!r_en || r_cmd.access_bytes > MAX_ACCESS_BYTES ||
                    r_off >= TRACK_BYTES) begin
                    n_res.access_ignored = 1'b1;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_w      = r_off[WW+1:2];
                    n_second = r_cmd.access_bytes > SINGLE_WORD_BYTES;
                    n_state  = S_MRD;
                end
            end
            S_MRD: begin
                mem_re  = 1'b1;
                n_state = S_MWR;
            end
            S_MWR: begin
                mem_we = 1'b1;
                if (r_second && next_w < (WW+1)'(TRACK_WORDS)) begin
                    n_w      = next_w[WW-1:0];
                    n_second = 1'b0;
                    n_state  = S_MRD;
                end else begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SRD: begin
                if (r_cur == CW'(TRACK_WORDS)) begin
                    if (r_open) begin
                        n_state = S_SF1;
                    end else begin
                        n_res.scan_done = 1'b1;
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_cur[WW-1:3];
                    n_state   = S_SBIT;
                end
            end
            S_SBIT: begin
                if (cur_bit) begin
                    if (!r_open) begin
                        n_open  = 1'b1;
                        n_first = r_cur[WW-1:0];
                    end
                    n_last = r_cur[WW-1:0];
                    n_cur  = next_cur;
                    if (next_cur == CW'(TRACK_WORDS) || next_cur[2:0] == 3'd0) begin
                        n_state = S_SRD;
                    end
                end else if (r_open) begin
                    n_state = S_SF1;
                end else begin
                    n_cur = next_cur;
                    if (next_cur == CW'(TRACK_WORDS) || next_cur[2:0] == 3'd0) begin
                        n_state = S_SRD;
                    end
                end
            end
            S_SF1: begin
                n_res.first_addr = word_addr;
                n_open  = 1'b0;
                n_state = S_SF2;
            end
            S_SF2: begin
                n_res.last_addr   = word_addr;
                n_res.range_bytes = 15'(32'(run_words) << 2);
                n_res.range_found = 1'b1;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_done  <= 1'b0;
            r_base  <= '0;
            r_en    <= 1'b0;
            r_cur   <= '0;
            r_open  <= 1'b0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_base  <= n_base;
            r_en    <= n_en;
            r_cur   <= n_cur;
            r_open  <= n_open;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_res    <= n_res;
        r_off    <= n_off;
        r_w      <= n_w;
        r_second <= n_second;
        r_first  <= n_first;
        r_last   <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

endmodule
